// ----- rtl/core/rdmrqs_pkg.sv -----
// Shared constants, codes and types of the request queue sequencer.
`default_nettype none

package rdmrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_WAITERS = 15;
    localparam int TAG_BITS    = 8;

    localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WAIT_W    = $clog2(MAX_WAITERS + 1);
    localparam int OPC_W     = 3;
    localparam int STATUS_W  = 4;
    localparam int KIND_W    = 3;
    localparam int OUTCOME_W = 2;
    localparam int WCNT_W    = 4;
    localparam int LIMIT_W   = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 5'd16;
    localparam logic [REG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;

    localparam logic [STATUS_W-1:0] LINK_STATUS_OK = 4'd0;

    localparam logic [OPC_W-1:0] OPC_ENQUEUE   = 3'd0;
    localparam logic [OPC_W-1:0] OPC_PAUSE     = 3'd1;
    localparam logic [OPC_W-1:0] OPC_RESUME    = 3'd2;
    localparam logic [OPC_W-1:0] OPC_REPLY     = 3'd3;
    localparam logic [OPC_W-1:0] OPC_DISC_REQ  = 3'd4;
    localparam logic [OPC_W-1:0] OPC_DISC_DONE = 3'd5;

    localparam logic [KIND_W-1:0] KIND_SEND        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISC_START  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISC_NOTIFY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY_REPLY = 3'd4;

    localparam logic [OUTCOME_W-1:0] OUT_PASS      = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_DROPPED   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_BAD_MERGE = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_MERGED    = 2'd3;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_PAUSE,
        OP_RESUME,
        OP_REPLY,
        OP_DISC_REQ,
        OP_DISC_DONE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [TAG_BITS-1:0] tag;
        logic [STATUS_W-1:0] status;
        logic                rep_fail;
        logic                rep_more;
        logic                merge_ok;
        logic                full_req;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/rdmrqs_ram.sv -----
// Generic single write port RAM with registered read.
`default_nettype none

module rdmrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/rdmrqs_front.sv -----
// Front end: command decode, reply classification and a two-entry command queue.
`default_nettype none

module rdmrqs_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic [rdmrqs_pkg::OPC_W-1:0]       i_opcode,
    input  wire logic [rdmrqs_pkg::TAG_BITS-1:0]    i_request_tag,
    input  wire logic [rdmrqs_pkg::STATUS_W-1:0]    i_link_status,
    input  wire logic                               i_has_response,
    input  wire logic                               i_is_ack_overflow,
    input  wire logic                               i_merge_ok,
    input  wire logic                               i_full_discovery,
    output logic                                    o_cmd_valid,
    output rdmrqs_pkg::t_cmd                        o_cmd,
    input  wire logic                               i_cmd_pop
);

    rdmrqs_pkg::t_cmd dec_cmd;
    logic             dec_known;
    logic             push;
    logic             pop;

    rdmrqs_pkg::t_cmd r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_comb begin
        dec_known        = 1'b1;
        dec_cmd.op       = rdmrqs_pkg::OP_PAUSE;
        dec_cmd.tag      = i_request_tag;
        dec_cmd.status   = i_link_status;
        dec_cmd.rep_fail = (i_link_status != rdmrqs_pkg::LINK_STATUS_OK) || !i_has_response;
        dec_cmd.rep_more = (i_link_status == rdmrqs_pkg::LINK_STATUS_OK) && i_has_response
                           && i_is_ack_overflow;
        dec_cmd.merge_ok = i_merge_ok;
        dec_cmd.full_req = i_full_discovery;
        case (i_opcode)
            rdmrqs_pkg::OPC_ENQUEUE:   dec_cmd.op = rdmrqs_pkg::OP_ENQ;
            rdmrqs_pkg::OPC_PAUSE:     dec_cmd.op = rdmrqs_pkg::OP_PAUSE;
            rdmrqs_pkg::OPC_RESUME:    dec_cmd.op = rdmrqs_pkg::OP_RESUME;
            rdmrqs_pkg::OPC_REPLY:     dec_cmd.op = rdmrqs_pkg::OP_REPLY;
            rdmrqs_pkg::OPC_DISC_REQ:  dec_cmd.op = rdmrqs_pkg::OP_DISC_REQ;
            rdmrqs_pkg::OPC_DISC_DONE: dec_cmd.op = rdmrqs_pkg::OP_DISC_DONE;
            default:                   dec_known  = 1'b0;
        endcase
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign push        = i_start && !o_busy && dec_known;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rdmrqs_back.sv -----
// Back end: request store, sequencing state and result generation.
`default_nettype none

module rdmrqs_back (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [rdmrqs_pkg::LIMIT_W-1:0]      i_limit,
    input  wire logic                                i_cmd_valid,
    input  wire rdmrqs_pkg::t_cmd                    i_cmd,
    output logic                                     o_cmd_pop,
    output logic                                     o_valid,
    output logic [rdmrqs_pkg::KIND_W-1:0]            o_kind,
    output logic [rdmrqs_pkg::TAG_BITS-1:0]          o_tag,
    output logic [rdmrqs_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic [rdmrqs_pkg::STATUS_W-1:0]          o_reported_status,
    output logic                                     o_full_sweep,
    output logic [rdmrqs_pkg::WCNT_W-1:0]            o_waiter_count,
    output logic                                     o_last
);

    localparam int CMP_W = (rdmrqs_pkg::COUNT_W > rdmrqs_pkg::LIMIT_W) ?
                           rdmrqs_pkg::COUNT_W : rdmrqs_pkg::LIMIT_W;

    typedef enum logic [2:0] {S_IDLE, S_WR, S_RD, S_EXEC, S_NA} t_state;

    typedef struct packed {
        logic [rdmrqs_pkg::KIND_W-1:0]    kind;
        logic [rdmrqs_pkg::TAG_BITS-1:0]  tag;
        logic [rdmrqs_pkg::OUTCOME_W-1:0] outcome;
        logic [rdmrqs_pkg::STATUS_W-1:0]  status;
        logic                             full;
        logic [rdmrqs_pkg::WCNT_W-1:0]    waiters;
    } t_res;

    function automatic t_res mk_res(
        input logic [rdmrqs_pkg::KIND_W-1:0]    kind,
        input logic [rdmrqs_pkg::TAG_BITS-1:0]  tag,
        input logic [rdmrqs_pkg::OUTCOME_W-1:0] outcome,
        input logic [rdmrqs_pkg::STATUS_W-1:0]  status,
        input logic                             full,
        input logic [rdmrqs_pkg::WCNT_W-1:0]    waiters
    );
        t_res r;
        r.kind    = kind;
        r.tag     = tag;
        r.outcome = outcome;
        r.status  = status;
        r.full    = full;
        r.waiters = waiters;
        return r;
    endfunction

    function automatic logic [rdmrqs_pkg::PTR_W-1:0] ptr_inc(
        input logic [rdmrqs_pkg::PTR_W-1:0] p
    );
        logic [rdmrqs_pkg::PTR_W-1:0] r;
        if (p == rdmrqs_pkg::PTR_W'(rdmrqs_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    t_state                              r_state, n_state;
    rdmrqs_pkg::t_cmd                    r_cmd, n_cmd;
    logic                                r_drop, n_drop;
    logic [rdmrqs_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [rdmrqs_pkg::PTR_W-1:0]        r_head, n_head;
    logic [rdmrqs_pkg::PTR_W-1:0]        r_tail, n_tail;
    logic                                r_inflight, n_inflight;
    logic                                r_en, n_en;
    logic                                r_ovf, n_ovf;
    logic [rdmrqs_pkg::WAIT_W-1:0]       r_wait, n_wait;
    logic                                r_wfull, n_wfull;
    logic [rdmrqs_pkg::WAIT_W-1:0]       r_run, n_run;
    logic                                r_na, n_na;
    logic                                r_valid, n_valid;
    logic                                r_last, n_last;
    t_res                                r_res, n_res;

    logic                                ram_we;
    logic                                ram_re;
    logic [rdmrqs_pkg::TAG_BITS-1:0]     ram_rdata;
    logic                                call_na;
    logic                                na_fire;
    logic                                cpl;
    logic [rdmrqs_pkg::OUTCOME_W-1:0]    cpl_outcome;
    logic [rdmrqs_pkg::STATUS_W-1:0]     cpl_status;
    logic [CMP_W-1:0]                    lim_c;
    logic [CMP_W-1:0]                    dep_c;
    logic [CMP_W-1:0]                    lim_eff;
    logic                                q_full;

    rdmrqs_ram #(
        .WIDTH (rdmrqs_pkg::TAG_BITS),
        .DEPTH (rdmrqs_pkg::QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_cmd.tag),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign lim_c   = CMP_W'(i_limit);
    assign dep_c   = CMP_W'(rdmrqs_pkg::QUEUE_DEPTH);
    assign lim_eff = (lim_c > dep_c) ? dep_c : lim_c;
    assign q_full  = CMP_W'(r_count) >= lim_eff;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_drop      = r_drop;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_inflight  = r_inflight;
        n_en        = r_en;
        n_ovf       = r_ovf;
        n_wait      = r_wait;
        n_wfull     = r_wfull;
        n_run       = r_run;
        n_na        = r_na;
        n_valid     = 1'b0;
        n_last      = r_last;
        n_res       = r_res;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        call_na     = 1'b0;
        cpl         = 1'b0;
        cpl_outcome = rdmrqs_pkg::OUT_PASS;
        cpl_status  = rdmrqs_pkg::LINK_STATUS_OK;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = S_WR;
                end
            end
            S_WR: begin
                n_drop = 1'b0;
                if (r_cmd.op == rdmrqs_pkg::OP_ENQ) begin
                    if (q_full) begin
                        n_drop = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        n_tail  = ptr_inc(r_tail);
                        n_count = r_count + 1'b1;
                    end
                end
                n_state = S_RD;
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = r_na ? S_NA : S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_cmd.op)
                    rdmrqs_pkg::OP_ENQ: begin
                        if (r_drop) begin
                            n_valid = 1'b1;
                            n_res   = mk_res(rdmrqs_pkg::KIND_COMPLETE, r_cmd.tag,
                                             rdmrqs_pkg::OUT_DROPPED, '0, 1'b0, '0);
                        end else begin
                            call_na = 1'b1;
                        end
                    end
                    rdmrqs_pkg::OP_PAUSE: begin
                        n_en = 1'b0;
                    end
                    rdmrqs_pkg::OP_RESUME: begin
                        n_en    = 1'b1;
                        call_na = 1'b1;
                    end
                    rdmrqs_pkg::OP_REPLY: begin
                        n_inflight = 1'b0;
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_res   = mk_res(rdmrqs_pkg::KIND_EMPTY_REPLY, '0,
                                             rdmrqs_pkg::OUT_PASS, '0, 1'b0, '0);
                        end else if (r_ovf) begin
                            if (r_cmd.rep_fail) begin
                                cpl        = 1'b1;
                                cpl_status = r_cmd.status;
                            end else if (!r_cmd.merge_ok) begin
                                cpl         = 1'b1;
                                cpl_outcome = rdmrqs_pkg::OUT_BAD_MERGE;
                            end else if (!r_cmd.rep_more) begin
                                cpl         = 1'b1;
                                cpl_outcome = rdmrqs_pkg::OUT_MERGED;
                            end else begin
                                n_inflight = 1'b1;
                                n_valid    = 1'b1;
                                n_res      = mk_res(rdmrqs_pkg::KIND_SEND, ram_rdata,
                                                    rdmrqs_pkg::OUT_PASS, '0, 1'b0, '0);
                            end
                        end else if (r_cmd.rep_more) begin
                            n_ovf      = 1'b1;
                            n_inflight = 1'b1;
                            n_valid    = 1'b1;
                            n_res      = mk_res(rdmrqs_pkg::KIND_SEND, ram_rdata,
                                                rdmrqs_pkg::OUT_PASS, '0, 1'b0, '0);
                        end else begin
                            cpl        = 1'b1;
                            cpl_status = r_cmd.status;
                        end
                    end
                    rdmrqs_pkg::OP_DISC_REQ: begin
                        if (r_wait != rdmrqs_pkg::WAIT_W'(rdmrqs_pkg::MAX_WAITERS)) begin
                            n_wait = r_wait + 1'b1;
                        end
                        if (r_cmd.full_req) begin
                            n_wfull = 1'b1;
                        end
                        call_na = 1'b1;
                    end
                    rdmrqs_pkg::OP_DISC_DONE: begin
                        if (r_run != '0) begin
                            n_valid = 1'b1;
                            n_res   = mk_res(rdmrqs_pkg::KIND_DISC_NOTIFY, '0,
                                             rdmrqs_pkg::OUT_PASS, '0, 1'b0,
                                             rdmrqs_pkg::WCNT_W'(r_run));
                            n_run   = '0;
                            call_na = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (cpl) begin
                    n_valid = 1'b1;
                    n_res   = mk_res(rdmrqs_pkg::KIND_COMPLETE, ram_rdata, cpl_outcome,
                                     cpl_status, 1'b0, '0);
                    n_head  = ptr_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_ovf   = 1'b0;
                    call_na = 1'b1;
                end
            end
            S_NA: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_na    = 1'b0;
                n_state = S_IDLE;
                if (r_wait != '0) begin
                    n_res   = mk_res(rdmrqs_pkg::KIND_DISC_START, '0,
                                     rdmrqs_pkg::OUT_PASS, '0, r_wfull, '0);
                    n_run   = r_wait;
                    n_wait  = '0;
                    n_wfull = 1'b0;
                end else begin
                    n_inflight = 1'b1;
                    n_res      = mk_res(rdmrqs_pkg::KIND_SEND, ram_rdata,
                                        rdmrqs_pkg::OUT_PASS, '0, 1'b0, '0);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next action fires on the state left behind by the primary action
        na_fire = n_en && !n_inflight && (n_run == '0) && ((n_wait != '0) || (n_count != '0));
        if (r_state == S_EXEC) begin
            n_na   = call_na && na_fire;
            n_last = !(call_na && na_fire);
            if (call_na && na_fire) begin
                n_state = S_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_inflight <= 1'b0;
            r_en       <= 1'b1;
            r_ovf      <= 1'b0;
            r_wait     <= '0;
            r_wfull    <= 1'b0;
            r_run      <= '0;
            r_na       <= 1'b0;
            r_valid    <= 1'b0;
            r_drop     <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd      <= n_cmd;
            r_drop     <= n_drop;
            r_count    <= n_count;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_inflight <= n_inflight;
            r_en       <= n_en;
            r_ovf      <= n_ovf;
            r_wait     <= n_wait;
            r_wfull    <= n_wfull;
            r_run      <= n_run;
            r_na       <= n_na;
            r_valid    <= n_valid;
            r_last     <= n_last;
            r_res      <= n_res;
        end
    end

    assign o_valid           = r_valid;
    assign o_kind            = r_res.kind;
    assign o_tag             = r_res.tag;
    assign o_outcome         = r_res.outcome;
    assign o_reported_status = r_res.status;
    assign o_full_sweep      = r_res.full;
    assign o_waiter_count    = r_res.waiters;
    assign o_last            = r_last;

`ifndef SYNTHESIS
    a_send_sets_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_res.kind == rdmrqs_pkg::KIND_SEND) |-> r_inflight)
        else $error("send issued without in-flight flag");

    a_disc_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_res.kind == rdmrqs_pkg::KIND_DISC_START) |-> (r_run != '0))
        else $error("discovery started with no running count");

    a_ovf_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_inflight && (r_count != '0))
        else $error("overflow sequence active without head in flight");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_last |=> ##1 (r_valid && r_last))
        else $error("second result of a transfer missing");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rdm_request_queue_sequencer_top.sv -----
// Top level of the request queue sequencer: config registers, front end and back end.
//
//  channel   | ports                                 | handshake
//  ----------+---------------------------------------+-------------------------------
//  command   | start, busy, i_opcode .. i_full_disc. | transfer when start && !busy
//  result    | o_valid, o_kind .. o_waiter_count,    | one-cycle strobe o_valid,
//            | o_last                                | no back-pressure
//  config    | psel, penable, pwrite, paddr, pwdata, | APB write, pready tied high
//            | prdata, pready                        |
//
//  Command transfers with a known opcode are registered into a two-entry queue; busy is
//  high while it is full. The back end steps through pop, store write, store read and
//  execute per command, then store re-read and issue if a send or discovery start follows,
//  and pops the next command only from idle. Results are registered in execute and in issue;
//  when both give one, the issue result is the second.
//  Reset is synchronous; no clearing pass, store data is only used where it was written.
`default_nettype none

module rdm_request_queue_sequencer_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [rdmrqs_pkg::OPC_W-1:0]        i_opcode,
    input  wire logic [rdmrqs_pkg::TAG_BITS-1:0]     i_request_tag,
    input  wire logic [rdmrqs_pkg::STATUS_W-1:0]     i_link_status,
    input  wire logic                                i_has_response,
    input  wire logic                                i_is_ack_overflow,
    input  wire logic                                i_merge_ok,
    input  wire logic                                i_full_discovery,
    output logic                                     o_valid,
    output logic [rdmrqs_pkg::KIND_W-1:0]            o_kind,
    output logic [rdmrqs_pkg::TAG_BITS-1:0]          o_tag,
    output logic [rdmrqs_pkg::OUTCOME_W-1:0]         o_outcome,
    output logic [rdmrqs_pkg::STATUS_W-1:0]          o_reported_status,
    output logic                                     o_full_sweep,
    output logic [rdmrqs_pkg::WCNT_W-1:0]            o_waiter_count,
    output logic                                     o_last,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rdmrqs_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [rdmrqs_pkg::DATA_W-1:0]       pwdata,
    output logic      [rdmrqs_pkg::DATA_W-1:0]       prdata,
    output logic                                     pready
);

    logic [rdmrqs_pkg::LIMIT_W-1:0] r_limit;
    logic                           cfg_wr;
    logic                           cmd_valid;
    logic                           cmd_pop;
    rdmrqs_pkg::t_cmd               cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[rdmrqs_pkg::ADDR_W-1:2] == rdmrqs_pkg::REG_QUEUE_LIMIT);
    assign prdata = (paddr[rdmrqs_pkg::ADDR_W-1:2] == rdmrqs_pkg::REG_QUEUE_LIMIT) ?
                    rdmrqs_pkg::DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rdmrqs_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            r_limit <= pwdata[rdmrqs_pkg::LIMIT_W-1:0];
        end
    end

    rdmrqs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_opcode          (i_opcode),
        .i_request_tag     (i_request_tag),
        .i_link_status     (i_link_status),
        .i_has_response    (i_has_response),
        .i_is_ack_overflow (i_is_ack_overflow),
        .i_merge_ok        (i_merge_ok),
        .i_full_discovery  (i_full_discovery),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_pop         (cmd_pop)
    );

    rdmrqs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_limit           (r_limit),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd),
        .o_cmd_pop         (cmd_pop),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_tag             (o_tag),
        .o_outcome         (o_outcome),
        .o_reported_status (o_reported_status),
        .o_full_sweep      (o_full_sweep),
        .o_waiter_count    (o_waiter_count),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire

// ----- dv/tb_rdm_request_queue_sequencer_top.sv -----
// Self-checking testbench of the request queue sequencer: driver, monitor, predictor.
module tb_rdm_request_queue_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rdmrqs_pkg::*;

    localparam logic [OPC_W-1:0] OPC_RSVD_LO = 3'd6;
    localparam logic [OPC_W-1:0] OPC_RSVD_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic [TAG_BITS-1:0] tag;
        logic [STATUS_W-1:0] status;
        logic                has_resp;
        logic                ack_ovf;
        logic                merge_ok;
        logic                full_disc;
    } t_link_cmd;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TAG_BITS-1:0]  tag;
        logic [OUTCOME_W-1:0] outcome;
        logic [STATUS_W-1:0]  status;
        logic                 full_sweep;
        logic [WCNT_W-1:0]    waiters;
        logic                 last;
    } t_action;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_link_cmd            drv_cmd = '0;
    logic                 o_valid;
    logic [KIND_W-1:0]    o_kind;
    logic [TAG_BITS-1:0]  o_tag;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [STATUS_W-1:0]  o_reported_status;
    logic                 o_full_sweep;
    logic [WCNT_W-1:0]    o_waiter_count;
    logic                 o_last;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    t_link_cmd   cmd_pending[$];
    t_action     step_actions[$];
    t_action     expected_actions[$];
    logic        cmd_taken = 1'b0;
    int unsigned sender_idle_pct = 0;
    int unsigned traffic_made = 0;
    int unsigned mismatches = 0;

    // predictor state
    logic [TAG_BITS-1:0] tag_store [QUEUE_DEPTH];
    int unsigned         q_count = 0;
    int unsigned         q_head = 0;
    int unsigned         q_tail = 0;
    bit                  in_flight = 1'b0;
    bit                  send_en = 1'b1;
    bit                  ovf_active = 1'b0;
    int unsigned         pend_waiters = 0;
    bit                  pend_full = 1'b0;
    int unsigned         run_waiters = 0;
    logic [LIMIT_W-1:0]  q_limit = LIMIT_RESET;

    rdm_request_queue_sequencer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (drv_cmd.opcode),
        .i_request_tag     (drv_cmd.tag),
        .i_link_status     (drv_cmd.status),
        .i_has_response    (drv_cmd.has_resp),
        .i_is_ack_overflow (drv_cmd.ack_ovf),
        .i_merge_ok        (drv_cmd.merge_ok),
        .i_full_discovery  (drv_cmd.full_disc),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_tag             (o_tag),
        .o_outcome         (o_outcome),
        .o_reported_status (o_reported_status),
        .o_full_sweep      (o_full_sweep),
        .o_waiter_count    (o_waiter_count),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    task emit_action(input logic [KIND_W-1:0] kind, input logic [TAG_BITS-1:0] tag,
                     input logic [OUTCOME_W-1:0] outcome, input logic [STATUS_W-1:0] status,
                     input logic full_sweep, input int unsigned waiters);
        t_action a;
        a.kind       = kind;
        a.tag        = tag;
        a.outcome    = outcome;
        a.status     = status;
        a.full_sweep = full_sweep;
        a.waiters    = waiters[WCNT_W-1:0];
        a.last       = 1'b0;
        step_actions = {step_actions, a};
    endtask

    task dispatch_next;
        if (send_en && !in_flight && run_waiters == 0) begin
            if (pend_waiters != 0) begin
                run_waiters  = pend_waiters;
                pend_waiters = 0;
                emit_action(KIND_DISC_START, '0, OUT_PASS, '0, pend_full, 0);
                pend_full = 1'b0;
            end else if (q_count != 0) begin
                in_flight = 1'b1;
                emit_action(KIND_SEND, tag_store[q_head], OUT_PASS, '0, 1'b0, 0);
            end
        end
    endtask

    task retire_head(input logic [OUTCOME_W-1:0] outcome, input logic [STATUS_W-1:0] status);
        emit_action(KIND_COMPLETE, tag_store[q_head], outcome, status, 1'b0, 0);
        if (q_count != 0) begin
            q_head = (q_head + 1) % QUEUE_DEPTH;
            q_count--;
        end
        ovf_active = 1'b0;
        dispatch_next();
    endtask

    task model_command(input t_link_cmd c);
        int unsigned lim;
        step_actions.delete();
        lim = (q_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : q_limit;
        case (c.opcode)
            OPC_ENQUEUE: begin
                if (q_count >= lim) begin
                    emit_action(KIND_COMPLETE, c.tag, OUT_DROPPED, '0, 1'b0, 0);
                end else begin
                    tag_store[q_tail] = c.tag;
                    q_tail = (q_tail + 1) % QUEUE_DEPTH;
                    q_count++;
                    dispatch_next();
                end
            end
            OPC_PAUSE: begin
                send_en = 1'b0;
            end
            OPC_RESUME: begin
                send_en = 1'b1;
                dispatch_next();
            end
            OPC_REPLY: begin
                in_flight = 1'b0;
                if (q_count == 0) begin
                    emit_action(KIND_EMPTY_REPLY, '0, OUT_PASS, '0, 1'b0, 0);
                end else if (ovf_active) begin
                    if (c.status != LINK_STATUS_OK || !c.has_resp) begin
                        retire_head(OUT_PASS, c.status);
                    end else if (!c.merge_ok) begin
                        retire_head(OUT_BAD_MERGE, '0);
                    end else if (!c.ack_ovf) begin
                        retire_head(OUT_MERGED, '0);
                    end else begin
                        in_flight = 1'b1;
                        emit_action(KIND_SEND, tag_store[q_head], OUT_PASS, '0, 1'b0, 0);
                    end
                end else if (c.status == LINK_STATUS_OK && c.has_resp && c.ack_ovf) begin
                    ovf_active = 1'b1;
                    in_flight  = 1'b1;
                    emit_action(KIND_SEND, tag_store[q_head], OUT_PASS, '0, 1'b0, 0);
                end else begin
                    retire_head(OUT_PASS, c.status);
                end
            end
            OPC_DISC_REQ: begin
                if (pend_waiters < MAX_WAITERS) pend_waiters++;
                if (c.full_disc) pend_full = 1'b1;
                dispatch_next();
            end
            OPC_DISC_DONE: begin
                if (run_waiters != 0) begin
                    emit_action(KIND_DISC_NOTIFY, '0, OUT_PASS, '0, 1'b0, run_waiters);
                    run_waiters = 0;
                    dispatch_next();
                end
            end
            default: ;
        endcase
        if (step_actions.size() != 0) step_actions[step_actions.size() - 1].last = 1'b1;
        expected_actions = {expected_actions, step_actions};
        step_actions.delete();
    endtask

    task check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                drv_cmd <= cmd_pending.pop_front();
                start   <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_action want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_actions.size() == 0) begin
                    $display("%0t ns: result with none expected, expected none, %s %0d tag %0d",
                             $time, "actual kind", o_kind, o_tag);
                    mismatches++;
                end else begin
                    want = expected_actions.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("tag", want.tag, o_tag);
                    check_field("outcome", want.outcome, o_outcome);
                    check_field("reported_status", want.status, o_reported_status);
                    check_field("full_sweep", want.full_sweep, o_full_sweep);
                    check_field("waiter_count", want.waiters, o_waiter_count);
                    check_field("last", want.last, o_last);
                end
            end
            cmd_taken <= start && !busy;
            if (start && !busy) model_command(drv_cmd);
        end
    end

    function automatic t_link_cmd rand_cmd(input logic [OPC_W-1:0] op);
        t_link_cmd c;
        c.opcode    = op;
        c.tag       = $urandom;
        c.status    = $urandom;
        c.has_resp  = $urandom;
        c.ack_ovf   = $urandom;
        c.merge_ok  = $urandom;
        c.full_disc = $urandom;
        return c;
    endfunction

    task add_cmd(input t_link_cmd c);
        cmd_pending = {cmd_pending, c};
        if (c.opcode <= OPC_DISC_DONE) traffic_made++;
    endtask

    task push_cmd(input logic [OPC_W-1:0] op, input logic [TAG_BITS-1:0] tag,
                  input logic [STATUS_W-1:0] status, input logic has_resp, input logic ack_ovf,
                  input logic merge_ok, input logic full_disc);
        add_cmd('{op, tag, status, has_resp, ack_ovf, merge_ok, full_disc});
    endtask

    task add_reply_chain;
        int unsigned style;
        int unsigned parts;
        int unsigned p;
        t_link_cmd   c;
        style = $urandom_range(9);
        c = rand_cmd(OPC_REPLY);
        if (style < 4) begin
            c.status = LINK_STATUS_OK;
            if (c.has_resp) c.ack_ovf = 1'b0;
            add_cmd(c);
        end else if (style < 6) begin
            if (c.status == LINK_STATUS_OK) c.has_resp = 1'b0;
            add_cmd(c);
        end else begin
            c.status = LINK_STATUS_OK;
            c.has_resp = 1'b1;
            c.ack_ovf = 1'b1;
            add_cmd(c);
            parts = $urandom_range(3);
            for (p = 0; p < parts; p++) begin
                c = rand_cmd(OPC_REPLY);
                c.status = LINK_STATUS_OK;
                c.has_resp = 1'b1;
                c.ack_ovf = 1'b1;
                c.merge_ok = 1'b1;
                add_cmd(c);
            end
            c = rand_cmd(OPC_REPLY);
            case ($urandom_range(2))
                0: begin
                    c.status = LINK_STATUS_OK;
                    c.has_resp = 1'b1;
                    c.merge_ok = 1'b1;
                    c.ack_ovf = 1'b0;
                end
                1: begin
                    c.status = LINK_STATUS_OK;
                    c.has_resp = 1'b1;
                    c.merge_ok = 1'b0;
                end
                default: begin
                    if (c.status == LINK_STATUS_OK) c.has_resp = 1'b0;
                end
            endcase
            add_cmd(c);
        end
    endtask

    task add_traffic(input int unsigned n);
        int unsigned goal;
        int unsigned sel;
        int unsigned k;
        int unsigned j;
        goal = traffic_made + n;
        while (traffic_made < goal) begin
            sel = $urandom_range(99);
            if (sel < 35) begin
                k = $urandom_range(3, 1);
                for (j = 0; j < k; j++) add_cmd(rand_cmd(OPC_ENQUEUE));
                for (j = 0; j < k; j++) add_reply_chain();
            end else if (sel < 50) begin
                k = ($urandom_range(19) == 0) ? $urandom_range(18, 16) : $urandom_range(4, 1);
                for (j = 0; j < k; j++) add_cmd(rand_cmd(OPC_DISC_REQ));
                add_cmd(rand_cmd(OPC_DISC_DONE));
                if ($urandom_range(3) == 0) add_cmd(rand_cmd(OPC_DISC_DONE));
            end else if (sel < 62) begin
                add_cmd(rand_cmd(OPC_PAUSE));
                k = $urandom_range(3);
                for (j = 0; j < k; j++) begin
                    if ($urandom_range(1)) add_cmd(rand_cmd(OPC_ENQUEUE));
                    else add_reply_chain();
                end
                add_cmd(rand_cmd(OPC_RESUME));
            end else if (sel < 75) begin
                k = $urandom_range(17, 4);
                for (j = 0; j < k; j++) add_cmd(rand_cmd(OPC_ENQUEUE));
            end else begin
                k = $urandom_range(3, 1);
                for (j = 0; j < k; j++) add_cmd(rand_cmd($urandom_range(7)));
            end
        end
    endtask

    task drain_and_settle;
        while (cmd_pending.size() != 0 || start || expected_actions.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task write_queue_limit(input logic [LIMIT_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = $urandom;
        word[LIMIT_W-1:0] = value;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_QUEUE_LIMIT, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        q_limit = value;
    endtask

    initial begin
        #2_000_000;
        $display("tb_rdm_request_queue_sequencer_top failed");
        $finish;
    end

    initial begin
        int unsigned phase_limit [6];
        int unsigned phase_idle [6];
        int unsigned ph;
        phase_limit[0] = 0;
        phase_limit[1] = 1;
        phase_limit[2] = 3;
        phase_limit[3] = 31;
        phase_limit[4] = 16;
        phase_limit[5] = $urandom_range(15, 2);
        phase_idle[0] = 0;
        phase_idle[1] = 87;
        phase_idle[2] = 28;
        phase_idle[3] = 87;
        phase_idle[4] = 0;
        phase_idle[5] = 28;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0);
        push_cmd(OPC_DISC_DONE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_RSVD_LO, 8'hFF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1);
        push_cmd(OPC_RSVD_HI, 8'h5A, 4'h5, 1'b0, 1'b1, 1'b0, 1'b1);
        push_cmd(OPC_ENQUEUE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_ENQUEUE, 8'hFF, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1);
        push_cmd(OPC_REPLY, 8'h00, 4'hF, 1'b0, 1'b1, 1'b1, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        push_cmd(OPC_PAUSE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_ENQUEUE, 8'hAA, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_DISC_REQ, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_DISC_REQ, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        push_cmd(OPC_RESUME, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_DISC_DONE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b0, 1'b1, 1'b0);
        push_cmd(OPC_ENQUEUE, 8'h55, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        push_cmd(OPC_ENQUEUE, 8'h01, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        // reply with nothing in flight still completes the head
        push_cmd(OPC_PAUSE, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_ENQUEUE, 8'h80, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_REPLY, 8'h00, 4'd7, 1'b1, 1'b0, 1'b0, 1'b0);
        push_cmd(OPC_RESUME, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0);

        for (ph = 0; ph < 6; ph++) begin
            drain_and_settle();
            write_queue_limit(phase_limit[ph]);
            sender_idle_pct = phase_idle[ph];
            @(posedge i_clk);
            if (ph == 0) begin
                // waiter count saturation
                repeat (17) add_cmd(rand_cmd(OPC_DISC_REQ));
                add_cmd(rand_cmd(OPC_DISC_DONE));
            end
            add_traffic(31);
            drain_and_settle();
            @(posedge i_clk);
            add_traffic(30);
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("tb_rdm_request_queue_sequencer_top passed");
        else
            $display("tb_rdm_request_queue_sequencer_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rdmrqs_pkg.sv
rtl/core/rdmrqs_ram.sv
rtl/core/rdmrqs_front.sv
rtl/core/rdmrqs_back.sv
rtl/core/rdm_request_queue_sequencer_top.sv
dv/tb_rdm_request_queue_sequencer_top.sv
